// ----- src/utf8d_pkg.sv -----
package utf8d_pkg;

  localparam int CP_W  = 21;
  localparam int LEN_W = 3;

  // what kind of character a queued word carries
  localparam logic [1:0] KIND_MULTI  = 2'd0;
  localparam logic [1:0] KIND_SINGLE = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_TRUNC  = 2'd3;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_length;
    logic [1:0]       kind;
  } tok_t;

  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] CONT_MASK  = 8'h3F;
  localparam logic [7:0] PAY2_MASK  = 8'h1F;
  localparam logic [7:0] PAY3_MASK  = 8'h0F;
  localparam logic [7:0] PAY4_MASK  = 8'h07;

endpackage

// ----- src/utf8d_front.sv -----
module utf8d_front
  import utf8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       tok_valid,
  output tok_t       tok
);

  logic [1:0]      bytes_left, bytes_left_next;
  logic [CP_W-1:0] partial_code, partial_code_next;
  logic [2:0]      seq_total, seq_total_next;
  logic [1:0]      dec_left;
  logic [CP_W-1:0] shifted;

  assign dec_left = bytes_left - 2'd1;
  assign shifted  = {partial_code[CP_W-7:0], in_byte[5:0] & CONT_MASK[5:0]};

  always_comb begin
    bytes_left_next   = bytes_left;
    partial_code_next = partial_code;
    seq_total_next    = seq_total;
    tok_valid         = 1'b0;
    tok.code_point    = '0;
    tok.seq_length    = '0;
    tok.kind          = KIND_MULTI;
    if (in_valid) begin
      if (bytes_left == 2'd0) begin
        if (in_byte == 8'h00) begin
          tok_valid = 1'b1;
          tok.kind  = KIND_END;
        end else if ((in_byte & LEAD4_MASK) == LEAD4_VAL ||
                     (in_byte & LEAD3_MASK) == LEAD3_VAL ||
                     (in_byte & LEAD2_MASK) == LEAD2_VAL) begin
          if ((in_byte & LEAD4_MASK) == LEAD4_VAL) begin
            partial_code_next = CP_W'(in_byte & PAY4_MASK);
            seq_total_next    = 3'd4;
            bytes_left_next   = 2'd3;
          end else if ((in_byte & LEAD3_MASK) == LEAD3_VAL) begin
            partial_code_next = CP_W'(in_byte & PAY3_MASK);
            seq_total_next    = 3'd3;
            bytes_left_next   = 2'd2;
          end else begin
            partial_code_next = CP_W'(in_byte & PAY2_MASK);
            seq_total_next    = 3'd2;
            bytes_left_next   = 2'd1;
          end
          if (in_last) begin
            // text ends right after a lead byte
            tok_valid         = 1'b1;
            tok.code_point    = partial_code_next;
            tok.seq_length    = 3'd1;
            tok.kind          = KIND_TRUNC;
            partial_code_next = '0;
            seq_total_next    = '0;
            bytes_left_next   = '0;
          end
        end else begin
          tok_valid      = 1'b1;
          tok.code_point = CP_W'(in_byte);
          tok.seq_length = 3'd1;
          tok.kind       = KIND_SINGLE;
        end
      end else begin
        partial_code_next = shifted;
        bytes_left_next   = dec_left;
        if (dec_left == 2'd0 || in_last) begin
          tok_valid      = 1'b1;
          tok.code_point = shifted;
          if (dec_left == 2'd0) begin
            tok.seq_length = seq_total;
            tok.kind       = KIND_MULTI;
          end else begin
            tok.seq_length = seq_total - {1'b0, dec_left};
            tok.kind       = KIND_TRUNC;
          end
          partial_code_next = '0;
          seq_total_next    = '0;
          bytes_left_next   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left   <= '0;
      partial_code <= '0;
      seq_total    <= '0;
    end else begin
      bytes_left   <= bytes_left_next;
      partial_code <= partial_code_next;
      seq_total    <= seq_total_next;
    end
  end

endmodule

// ----- src/utf8d_queue.sv -----
module utf8d_queue
  import utf8d_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tok_t push_tok,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output tok_t head_tok
);

  tok_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_tok   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- src/utf8d_back.sv -----
module utf8d_back
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  tok_t        head_tok,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_data,
  output logic [3:0]  out_user
);

  logic [CP_W-1:0] code_point;
  logic [2:0]      seq_length;
  logic            is_space, is_decimal_digit, text_end, truncated;
  logic            sp_next, dg_next;
  logic [7:0]      lo;

  assign pop = head_valid && (!out_valid || out_ready);
  assign lo  = head_tok.code_point[7:0];

  always_comb begin
    sp_next = 1'b0;
    dg_next = 1'b0;
    if (head_tok.kind == KIND_SINGLE) begin
      sp_next = (lo == 8'h0A) || (lo == 8'h0D) || (lo == 8'h09) || (lo == 8'h20);
      dg_next = (lo >= 8'h30) && (lo <= 8'h39);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      code_point       <= head_tok.code_point;
      seq_length       <= head_tok.seq_length;
      is_space         <= sp_next;
      is_decimal_digit <= dg_next;
      text_end         <= (head_tok.kind == KIND_END);
      truncated        <= (head_tok.kind == KIND_TRUNC);
    end
  end

  assign out_data = {seq_length, code_point};
  assign out_user = {truncated, text_end, is_decimal_digit, is_space};

endmodule

// ----- src/utf8_stream_decoder_unit.sv -----
// UTF-8 stream decoder.
// Input: one text byte per word on s_axis; s_axis_tlast marks the last byte
// of a text. Output: one word per decoded character on m_axis carrying the
// code point, the byte count and flags (space, digit, end of text on NUL,
// truncated when the text ends inside a multi-byte sequence).
// A byte that opens or continues a sequence without finishing it yields no
// output word unless it is the last byte of a text (then a truncated word);
// every other byte yields exactly one. Throughput: one byte per cycle while
// the queue is not full. An output word is pushed into the two-entry queue
// when the byte that completes it is accepted, and is loaded into the output
// register when the output side can take it.
// When m_axis_tready is low the output register holds its word and the
// queue absorbs up to two more results; s_axis_tready drops only when the
// queue is full. Decoding state lives in the front stage and waits on the
// output side only through that full flag.
// Reset (rst, synchronous) clears the partial sequence, empties the queue
// and drops m_axis_tvalid.
module utf8_stream_decoder_unit
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] seq_length
  output logic [3:0]  m_axis_tuser    // [0] is_space, [1] is_decimal_digit,
                                      // [2] text_end, [3] truncated
);

  logic accept, tok_valid, full, pop, head_valid;
  tok_t tok, head_tok;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  utf8d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  utf8d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (tok_valid),
    .push_tok   (tok),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_tok   (head_tok)
  );

  utf8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_tok   (head_tok),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_user   (m_axis_tuser)
  );

endmodule
